// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/pkf_pkg.sv =====
package pkf_pkg;

  localparam int DW            = 32;
  localparam int SW            = 33;
  localparam int PW            = 66;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AW            = 6;
  localparam int DIV_STEPS     = 33;
  localparam int CNTW          = 6;

  typedef logic [4:0] op_t;
  localparam op_t OP_IDLE     = 5'd0;
  localparam op_t OP_NOP      = 5'd1;
  localparam op_t OP_MUL_DT   = 5'd2;
  localparam op_t OP_VAR_ADDQ = 5'd3;
  localparam op_t OP_CLEAR    = 5'd4;
  localparam op_t OP_DIFF     = 5'd5;
  localparam op_t OP_MUL_MC   = 5'd6;
  localparam op_t OP_DIV_RND  = 5'd7;
  localparam op_t OP_APPLY    = 5'd8;
  localparam op_t OP_MUL_CR   = 5'd9;
  localparam op_t OP_SET_VAR  = 5'd10;
  localparam op_t OP_LOAD     = 5'd11;
  localparam op_t OP_MUL_SQ   = 5'd12;
  localparam op_t OP_ACC      = 5'd13;
  localparam op_t OP_DIV_ACC  = 5'd14;
  localparam op_t OP_SET_NIS  = 5'd15;
  localparam op_t OP_EMIT     = 5'd16;

  typedef logic [3:0] jc_t;
  localparam jc_t JC_NONE     = 4'd0;
  localparam jc_t JC_ALWAYS   = 4'd1;
  localparam jc_t JC_IS_UPD   = 4'd2;
  localparam jc_t JC_IS_QRY   = 4'd3;
  localparam jc_t JC_IS_RST   = 4'd4;
  localparam jc_t JC_NOT_INIT = 4'd5;
  localparam jc_t JC_WAIT_IN  = 4'd6;
  localparam jc_t JC_WAIT_DIV = 4'd7;
  localparam jc_t JC_WAIT_OUT = 4'd8;

  localparam logic [1:0] KIND_PRED = 2'd0;
  localparam logic [1:0] KIND_UPD  = 2'd1;
  localparam logic [1:0] KIND_QRY  = 2'd2;
  localparam logic [1:0] KIND_RST  = 2'd3;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [AW-1:0] A_IDLE = 6'd0;
  localparam logic [AW-1:0] A_RST  = 6'd6;
  localparam logic [AW-1:0] A_UPD  = 6'd7;
  localparam logic [AW-1:0] A_LOAD = 6'd27;
  localparam logic [AW-1:0] A_QRY  = 6'd28;
  localparam logic [AW-1:0] A_EMIT = 6'd41;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } ctl_t;

  typedef struct packed {
    op_t           op;
    logic [1:0]    axis;
    jc_t           jc;
    logic [AW-1:0] tgt;
    logic          last;
  } uword_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       init;
    logic       div_busy;
  } dp_sts_t;

  typedef struct packed {
    dp_sts_t dp;
    logic    in_fire;
    logic    out_busy;
  } sts_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [DW-1:0] dt;
    logic signed [DW-1:0] mx;
    logic signed [DW-1:0] my;
    logic signed [DW-1:0] mz;
    logic [DW-1:0]        mv;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic [DW-1:0]        variance;
    logic                 init;
    logic [DW-1:0]        nis;
    logic                 nisv;
  } res_t;

  function automatic uword_t uw(op_t o, logic [1:0] a, jc_t j, logic [AW-1:0] t, logic l);
    uword_t w;
    w.op   = o;
    w.axis = a;
    w.jc   = j;
    w.tgt  = t;
    w.last = l;
    return w;
  endfunction

  // microprogram
  function automatic uword_t urom(logic [AW-1:0] adr);
    uword_t w;
    unique case (adr)
      6'd0:  w = uw(OP_IDLE,     AX_X, JC_WAIT_IN,  A_IDLE, 1'b0);
      6'd1:  w = uw(OP_NOP,      AX_X, JC_IS_UPD,   A_UPD,  1'b0);
      6'd2:  w = uw(OP_NOP,      AX_X, JC_IS_QRY,   A_QRY,  1'b0);
      6'd3:  w = uw(OP_NOP,      AX_X, JC_IS_RST,   A_RST,  1'b0);
      6'd4:  w = uw(OP_MUL_DT,   AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd5:  w = uw(OP_VAR_ADDQ, AX_X, JC_ALWAYS,   A_EMIT, 1'b0);
      6'd6:  w = uw(OP_CLEAR,    AX_X, JC_ALWAYS,   A_EMIT, 1'b0);
      6'd7:  w = uw(OP_NOP,      AX_X, JC_NOT_INIT, A_LOAD, 1'b0);
      6'd8:  w = uw(OP_DIFF,     AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd9:  w = uw(OP_MUL_MC,   AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd10: w = uw(OP_DIV_RND,  AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd11: w = uw(OP_NOP,      AX_X, JC_WAIT_DIV, A_IDLE, 1'b0);
      6'd12: w = uw(OP_APPLY,    AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd13: w = uw(OP_DIFF,     AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd14: w = uw(OP_MUL_MC,   AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd15: w = uw(OP_DIV_RND,  AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd16: w = uw(OP_NOP,      AX_Y, JC_WAIT_DIV, A_IDLE, 1'b0);
      6'd17: w = uw(OP_APPLY,    AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd18: w = uw(OP_DIFF,     AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd19: w = uw(OP_MUL_MC,   AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd20: w = uw(OP_DIV_RND,  AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd21: w = uw(OP_NOP,      AX_Z, JC_WAIT_DIV, A_IDLE, 1'b0);
      6'd22: w = uw(OP_APPLY,    AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd23: w = uw(OP_MUL_CR,   AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd24: w = uw(OP_DIV_RND,  AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd25: w = uw(OP_NOP,      AX_X, JC_WAIT_DIV, A_IDLE, 1'b0);
      6'd26: w = uw(OP_SET_VAR,  AX_X, JC_ALWAYS,   A_EMIT, 1'b0);
      6'd27: w = uw(OP_LOAD,     AX_X, JC_ALWAYS,   A_EMIT, 1'b0);
      6'd28: w = uw(OP_NOP,      AX_X, JC_NOT_INIT, A_EMIT, 1'b0);
      6'd29: w = uw(OP_DIFF,     AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd30: w = uw(OP_MUL_SQ,   AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd31: w = uw(OP_ACC,      AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd32: w = uw(OP_DIFF,     AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd33: w = uw(OP_MUL_SQ,   AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd34: w = uw(OP_ACC,      AX_Y, JC_NONE,     A_IDLE, 1'b0);
      6'd35: w = uw(OP_DIFF,     AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd36: w = uw(OP_MUL_SQ,   AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd37: w = uw(OP_ACC,      AX_Z, JC_NONE,     A_IDLE, 1'b0);
      6'd38: w = uw(OP_DIV_ACC,  AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd39: w = uw(OP_NOP,      AX_X, JC_WAIT_DIV, A_IDLE, 1'b0);
      6'd40: w = uw(OP_SET_NIS,  AX_X, JC_NONE,     A_IDLE, 1'b0);
      6'd41: w = uw(OP_EMIT,     AX_X, JC_WAIT_OUT, A_IDLE, 1'b1);
      default: w = uw(OP_NOP,    AX_X, JC_ALWAYS,   A_IDLE, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/pkf_div.sv =====
`include "assert_macros.svh"

module pkf_div
  import pkf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          busy,
  output logic [SW-1:0] quot,
  output logic          ovf
);

  localparam logic [CNTW-1:0] LAST = CNTW'(DIV_STEPS - 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [SW-1:0]   rem_r;
  logic [SW-1:0]   dq_r;
  logic [SW-1:0]   dvs_r;
  logic            ovf_r;
  logic [SW:0]     sh_w;
  logic [SW:0]     trial_w;
  logic            ge_w;

  assign sh_w    = {rem_r, dq_r[SW-1]};
  assign trial_w = sh_w - {1'b0, dvs_r};
  assign ge_w    = sh_w >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == LAST) begin
      busy_r <= 1'b0;
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[PW-1:SW];
      dq_r  <= dividend[SW-1:0];
      dvs_r <= divisor;
      ovf_r <= dividend[PW-1:SW] >= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge_w ? trial_w[SW-1:0] : sh_w[SW-1:0];
      dq_r  <= {dq_r[SW-2:0], ge_w};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign quot = dq_r;
  assign ovf  = ovf_r | dq_r[SW-1];

  `ASSERT_RST(a_div_no_restart, clk, rst_n, start |-> !busy_r, "divider started while busy")
  `ASSERT_RST(a_div_goes_busy, clk, rst_n, start |=> busy_r, "divider did not go busy")

endmodule

// ===== rtl/core/pkf_seq.sv =====
`include "assert_macros.svh"

module pkf_seq
  import pkf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output ctl_t ctl
);

  logic [AW-1:0] pc_r;
  logic [AW-1:0] pc_nxt;
  uword_t        uw_w;
  logic          hold_w;
  logic          jump_w;

  assign uw_w = urom(pc_r);

  always_comb begin
    hold_w = 1'b0;
    jump_w = 1'b0;
    unique case (uw_w.jc)
      JC_NONE:     ;
      JC_ALWAYS:   jump_w = 1'b1;
      JC_IS_UPD:   jump_w = sts.dp.kind == KIND_UPD;
      JC_IS_QRY:   jump_w = sts.dp.kind == KIND_QRY;
      JC_IS_RST:   jump_w = sts.dp.kind == KIND_RST;
      JC_NOT_INIT: jump_w = !sts.dp.init;
      JC_WAIT_IN:  hold_w = !sts.in_fire;
      JC_WAIT_DIV: hold_w = sts.dp.div_busy;
      JC_WAIT_OUT: hold_w = sts.out_busy;
      default:     ;
    endcase
    if (hold_w) begin
      pc_nxt = pc_r;
    end else if (jump_w) begin
      pc_nxt = uw_w.tgt;
    end else if (uw_w.last) begin
      pc_nxt = A_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.op   = uw_w.op;
  assign ctl.axis = uw_w.axis;

  `ASSERT_ALW(a_seq_reset_idle, clk, !rst_n |=> (pc_r == A_IDLE), "pc not idle after reset")
  `ASSERT_RST(a_seq_in_range, clk, rst_n, pc_r <= A_EMIT, "pc beyond microprogram")

endmodule

// ===== rtl/core/pkf_dp.sv =====
module pkf_dp
  import pkf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          ctl,
  input  logic          in_fire,
  input  item_t         item,
  input  logic [DW-1:0] rate,
  output dp_sts_t       sts,
  output res_t          res
);

  localparam logic [DW-1:0] VAR_ONE = DW'(1) << FRAC_BITS;

  logic [1:0]           kind_r;
  logic signed [DW-1:0] dt_r;
  logic signed [DW-1:0] m_r [3];
  logic [DW-1:0]        rv_r;
  logic signed [DW-1:0] pos_r [3];
  logic [DW-1:0]        var_r;
  logic                 init_r;
  logic [SW-1:0]        mag_r;
  logic                 neg_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        acc_r;
  logic [DW-1:0]        nis_r;
  logic                 nisv_r;

  logic [SW-1:0]        s_w;
  logic signed [DW-1:0] m_sel;
  logic signed [DW-1:0] p_sel;
  logic [SW-1:0]        d_w;
  logic [SW-1:0]        mag_w;
  logic [DW-1:0]        dt_pos;
  logic [SW-1:0]        mul_a;
  logic [SW-1:0]        mul_b;
  logic [PW-1:0]        prod_w;
  logic                 is_mul;
  logic [PW-1:0]        qinc_w;
  logic [PW:0]          vsum_w;
  logic [DW-1:0]        vsat_w;
  logic [PW-1:0]        dvd_w;
  logic                 div_go;
  logic                 div_busy;
  logic [SW-1:0]        quot;
  logic                 ovf;
  logic [SW:0]          cadd_w;
  logic [SW:0]          np_w;

  assign s_w    = {1'b0, var_r} + {1'b0, rv_r};
  assign m_sel  = m_r[ctl.axis];
  assign p_sel  = pos_r[ctl.axis];
  assign d_w    = {m_sel[DW-1], m_sel} - {p_sel[DW-1], p_sel};
  assign mag_w  = d_w[SW-1] ? SW'(~d_w + 1'b1) : d_w;
  assign dt_pos = dt_r[DW-1] ? '0 : dt_r;

  always_comb begin
    is_mul = 1'b1;
    unique case (ctl.op) inside
      OP_MUL_DT: begin
        mul_a = {1'b0, dt_pos};
        mul_b = {1'b0, rate};
      end
      OP_MUL_MC: begin
        mul_a = mag_r;
        mul_b = {1'b0, var_r};
      end
      OP_MUL_CR: begin
        mul_a = {1'b0, var_r};
        mul_b = {1'b0, rv_r};
      end
      OP_MUL_SQ: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      default: begin
        mul_a  = mag_r;
        mul_b  = mag_r;
        is_mul = 1'b0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  assign qinc_w = prod_r >> FRAC_BITS;
  assign vsum_w = {{(PW-DW+1){1'b0}}, var_r} + {1'b0, qinc_w};
  assign vsat_w = (|vsum_w[PW:DW]) ? '1 : vsum_w[DW-1:0];

  // rounded quotients add half the divisor first
  assign div_go = (ctl.op == OP_DIV_RND) || (ctl.op == OP_DIV_ACC);
  assign dvd_w  = (ctl.op == OP_DIV_RND) ? prod_r + {{(PW-DW){1'b0}}, s_w[SW-1:1]} : acc_r;

  pkf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (dvd_w),
    .divisor  (s_w),
    .busy     (div_busy),
    .quot     (quot),
    .ovf      (ovf)
  );

  assign cadd_w = neg_r ? (SW+1)'(~{1'b0, quot} + 1'b1) : {1'b0, quot};
  assign np_w   = {{2{p_sel[DW-1]}}, p_sel} + cadd_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
      var_r    <= VAR_ONE;
      init_r   <= 1'b0;
    end else begin
      unique case (ctl.op) inside
        OP_VAR_ADDQ: begin
          if (init_r) begin
            var_r <= vsat_w;
          end
        end
        OP_CLEAR: begin
          pos_r[0] <= '0;
          pos_r[1] <= '0;
          pos_r[2] <= '0;
          var_r    <= VAR_ONE;
          init_r   <= 1'b0;
        end
        OP_APPLY:   pos_r[ctl.axis] <= np_w[DW-1:0];
        OP_SET_VAR: var_r <= quot[DW-1:0];
        OP_LOAD: begin
          pos_r[0] <= m_r[0];
          pos_r[1] <= m_r[1];
          pos_r[2] <= m_r[2];
          var_r    <= rv_r;
          init_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= item.kind;
      dt_r   <= item.dt;
      m_r[0] <= item.mx;
      m_r[1] <= item.my;
      m_r[2] <= item.mz;
      rv_r   <= (item.mv == '0) ? DW'(1) : item.mv;
      acc_r  <= '0;
      nis_r  <= '0;
      nisv_r <= 1'b0;
    end else begin
      unique case (ctl.op) inside
        OP_DIFF: begin
          mag_r <= mag_w;
          neg_r <= d_w[SW-1];
        end
        OP_ACC: acc_r <= acc_r + prod_r;
        OP_SET_NIS: begin
          nis_r  <= ovf ? '1 : quot[DW-1:0];
          nisv_r <= 1'b1;
        end
        default: ;
      endcase
    end
    if (is_mul) begin
      prod_r <= prod_w;
    end
  end

  assign sts.kind     = kind_r;
  assign sts.init     = init_r;
  assign sts.div_busy = div_busy;

  assign res.x        = pos_r[0];
  assign res.y        = pos_r[1];
  assign res.z        = pos_r[2];
  assign res.variance = var_r;
  assign res.init     = init_r;
  assign res.nis      = nis_r;
  assign res.nisv     = nisv_r;

endmodule

// ===== rtl/core/position_kalman_filter_3d.sv =====
// Constant-position Kalman filter for one 3D point, fixed point.
// Input channel (in_*): one beat per item; kind selects predict, update,
// innovation query or filter reset. A beat is taken when in_valid is high
// and in_stall is low; in_stall is low only while the sequencer is idle.
// Result channel (out_*): exactly one beat per input item, held in an
// output register until the receiver drops out_stall. The next input beat
// is taken while a result still waits; its result is written only after
// the waiting one has gone.
// Config channel (cfg_*): process noise rate, always ready; write it idle.
// A later update uses the shared one-bit-per-cycle divider four times,
// a query with an initialized filter once; predict, filter reset, the
// first update and a query before the first update do not use it.
// Items are handled one at a time; the next beat is taken the cycle after
// the result is written.
// Reset (rst_n low, synchronous): estimate 0, variance 1.0, not
// initialized, noise rate 0, no result pending.
module position_kalman_filter_3d
  import pkf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic signed [DW-1:0] in_elapsed_time,
  input  logic signed [DW-1:0] in_meas_x,
  input  logic signed [DW-1:0] in_meas_y,
  input  logic signed [DW-1:0] in_meas_z,
  input  logic [DW-1:0]        in_meas_variance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_est_x,
  output logic signed [DW-1:0] out_est_y,
  output logic signed [DW-1:0] out_est_z,
  output logic [DW-1:0]        out_est_variance,
  output logic                 out_is_initialized,
  output logic [DW-1:0]        out_nis,
  output logic                 out_nis_valid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DW-1:0]        cfg_process_noise_rate
);

`include "assert_macros.svh"

  ctl_t          ctl;
  sts_t          sts;
  dp_sts_t       dps;
  item_t         item;
  res_t          res;
  res_t          out_r;
  logic          out_valid_r;
  logic [DW-1:0] rate_r;
  logic          in_fire;
  logic          out_busy;
  logic          emit;

  assign in_stall  = ctl.op != OP_IDLE;
  assign in_fire   = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign emit      = (ctl.op == OP_EMIT) && !out_busy;
  assign cfg_ready = 1'b1;

  assign item.kind = in_kind;
  assign item.dt   = in_elapsed_time;
  assign item.mx   = in_meas_x;
  assign item.my   = in_meas_y;
  assign item.mz   = in_meas_z;
  assign item.mv   = in_meas_variance;

  assign sts.dp       = dps;
  assign sts.in_fire  = in_fire;
  assign sts.out_busy = out_busy;

  pkf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  pkf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_fire (in_fire),
    .item    (item),
    .rate    (rate_r),
    .sts     (dps),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rate_r <= cfg_process_noise_rate;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_est_x          = out_r.x;
  assign out_est_y          = out_r.y;
  assign out_est_z          = out_r.z;
  assign out_est_variance   = out_r.variance;
  assign out_is_initialized = out_r.init;
  assign out_nis            = out_r.nis;
  assign out_nis_valid      = out_r.nisv;

  `ASSERT_RST(a_take_closes, clk, rst_n, in_fire |=> in_stall, "input open after a beat")
  `ASSERT_RST(a_nis_needs_init, clk, rst_n, out_valid_r |-> (!out_r.nisv || out_r.init), "nis valid while uninitialized")

endmodule

// ===== tb/position_estimate_checker.sv =====
module position_estimate_checker
  import pkf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic signed [DW-1:0] in_elapsed_time,
  input  logic signed [DW-1:0] in_meas_x,
  input  logic signed [DW-1:0] in_meas_y,
  input  logic signed [DW-1:0] in_meas_z,
  input  logic [DW-1:0]        in_meas_variance,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [DW-1:0] out_est_x,
  input  logic signed [DW-1:0] out_est_y,
  input  logic signed [DW-1:0] out_est_z,
  input  logic [DW-1:0]        out_est_variance,
  input  logic                 out_is_initialized,
  input  logic [DW-1:0]        out_nis,
  input  logic                 out_nis_valid,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [DW-1:0]        cfg_process_noise_rate,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic [DW-1:0]        variance;
    logic                 tracking;
    logic [DW-1:0]        nis;
    logic                 nis_ok;
  } estimate_t;

  logic signed [DW-1:0] pos [3];
  logic [DW-1:0]        pos_var;
  logic                 tracking;
  logic [DW-1:0]        noise_rate;
  estimate_t            expected_estimates [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic void clear_track();
    pos[0]   = '0;
    pos[1]   = '0;
    pos[2]   = '0;
    pos_var  = DW'(1) << FRAC;
    tracking = 1'b0;
  endfunction

  function automatic estimate_t advance_estimate(logic [1:0] kind, logic signed [DW-1:0] dt,
                                                 logic signed [DW-1:0] mx,
                                                 logic signed [DW-1:0] my,
                                                 logic signed [DW-1:0] mz,
                                                 logic [DW-1:0] mv);
    estimate_t            e;
    logic signed [DW+1:0] meas [3];
    logic signed [DW+1:0] p;
    logic signed [DW+1:0] d;
    logic signed [DW+1:0] np;
    logic [SW-1:0]        r;
    logic [SW-1:0]        s;
    logic [SW-1:0]        mag;
    logic [SW-1:0]        corr;
    logic [63:0]          growth;
    logic [67:0]          sumsq;
    logic [67:0]          quo;
    int                   a;
    meas[0]  = {{2{mx[DW-1]}}, mx};
    meas[1]  = {{2{my[DW-1]}}, my};
    meas[2]  = {{2{mz[DW-1]}}, mz};
    r        = (mv == '0) ? SW'(1) : SW'(mv);
    e.nis    = '0;
    e.nis_ok = 1'b0;
    case (kind)
      KIND_PRED: begin
        if (tracking && !dt[DW-1] && dt != '0) begin
          growth  = (64'(dt) * 64'(noise_rate)) >> FRAC;
          growth  = growth + 64'(pos_var);
          pos_var = (growth > 64'hFFFF_FFFF) ? '1 : growth[DW-1:0];
        end
      end
      KIND_UPD: begin
        if (!tracking) begin
          pos[0]   = mx;
          pos[1]   = my;
          pos[2]   = mz;
          pos_var  = r[DW-1:0];
          tracking = 1'b1;
        end else begin
          s = SW'(pos_var) + r;
          for (a = 0; a < 3; a++) begin
            p      = {{2{pos[a][DW-1]}}, pos[a]};
            d      = meas[a] - p;
            mag    = d[DW+1] ? SW'(-d) : SW'(d);
            corr   = SW'((PW'(mag) * PW'(pos_var) + PW'(s >> 1)) / PW'(s));
            np     = d[DW+1] ? p - $signed({1'b0, corr}) : p + $signed({1'b0, corr});
            pos[a] = np[DW-1:0];
          end
          pos_var = DW'((PW'(pos_var) * PW'(r) + PW'(s >> 1)) / PW'(s));
        end
      end
      KIND_QRY: begin
        if (tracking) begin
          s     = SW'(pos_var) + r;
          sumsq = '0;
          for (a = 0; a < 3; a++) begin
            p     = {{2{pos[a][DW-1]}}, pos[a]};
            d     = meas[a] - p;
            mag   = d[DW+1] ? SW'(-d) : SW'(d);
            sumsq = sumsq + 68'(mag) * 68'(mag);
          end
          quo      = sumsq / 68'(s);
          e.nis    = (quo > 68'hFFFF_FFFF) ? '1 : quo[DW-1:0];
          e.nis_ok = 1'b1;
        end
      end
      default: clear_track();
    endcase
    e.x        = pos[0];
    e.y        = pos[1];
    e.z        = pos[2];
    e.variance = pos_var;
    e.tracking = tracking;
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    fail_count++;
    $display("%0t ns: %s mismatch at result %0d: got %h, expected %h",
             $time, what, checked, got, want);
  endtask

  task automatic check_result();
    estimate_t e;
    if (expected_estimates.size() == 0) begin
      report_mismatch("unexpected result beat", out_est_x, '0);
      return;
    end
    e = expected_estimates.pop_front();
    if (out_est_x !== e.x) report_mismatch("est_x", out_est_x, e.x);
    if (out_est_y !== e.y) report_mismatch("est_y", out_est_y, e.y);
    if (out_est_z !== e.z) report_mismatch("est_z", out_est_z, e.z);
    if (out_est_variance !== e.variance)
      report_mismatch("est_variance", out_est_variance, e.variance);
    if (out_is_initialized !== e.tracking)
      report_mismatch("is_initialized", DW'(out_is_initialized), DW'(e.tracking));
    if (out_nis !== e.nis) report_mismatch("nis", out_nis, e.nis);
    if (out_nis_valid !== e.nis_ok)
      report_mismatch("nis_valid", DW'(out_nis_valid), DW'(e.nis_ok));
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      noise_rate = '0;
      clear_track();
      expected_estimates.delete();
    end else begin
      if (cfg_valid && cfg_ready) noise_rate = cfg_process_noise_rate;
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall)
        expected_estimates.push_back(advance_estimate(in_kind, in_elapsed_time, in_meas_x,
                                                      in_meas_y, in_meas_z,
                                                      in_meas_variance));
    end
    pending = expected_estimates.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pkf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SEGMENTS      = 10;
  localparam int SEGMENT_ITEMS = 125;
  localparam int TAIL_CYCLES   = 200;

  localparam logic [DW-1:0] ONE     = 32'h0001_0000;
  localparam logic [DW-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] U_MAX   = 32'hFFFF_FFFF;

  logic                 clk                    = 1'b0;
  logic                 rst_n                  = 1'b0;
  logic                 in_valid               = 1'b0;
  logic [1:0]           in_kind                = '0;
  logic signed [DW-1:0] in_elapsed_time        = '0;
  logic signed [DW-1:0] in_meas_x              = '0;
  logic signed [DW-1:0] in_meas_y              = '0;
  logic signed [DW-1:0] in_meas_z              = '0;
  logic [DW-1:0]        in_meas_variance       = '0;
  logic                 out_stall              = 1'b0;
  logic                 cfg_valid              = 1'b0;
  logic [DW-1:0]        cfg_process_noise_rate = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic signed [DW-1:0] out_est_x;
  logic signed [DW-1:0] out_est_y;
  logic signed [DW-1:0] out_est_z;
  logic [DW-1:0]        out_est_variance;
  logic                 out_is_initialized;
  logic [DW-1:0]        out_nis;
  logic                 out_nis_valid;
  logic                 cfg_ready;

  int fail_count;
  int pending;
  int checked;

  logic          calm        = 1'b0;
  int            hold_left   = 0;
  int            cycle_count = 0;
  int            rate_writes = 0;
  int            kind_count [4] = '{0, 0, 0, 0};
  logic [DW-1:0] base_x, base_y, base_z;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  position_kalman_filter_3d u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_elapsed_time        (in_elapsed_time),
    .in_meas_x              (in_meas_x),
    .in_meas_y              (in_meas_y),
    .in_meas_z              (in_meas_z),
    .in_meas_variance       (in_meas_variance),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_est_x              (out_est_x),
    .out_est_y              (out_est_y),
    .out_est_z              (out_est_z),
    .out_est_variance       (out_est_variance),
    .out_is_initialized     (out_is_initialized),
    .out_nis                (out_nis),
    .out_nis_valid          (out_nis_valid),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_process_noise_rate (cfg_process_noise_rate)
  );

  position_estimate_checker u_chk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_elapsed_time        (in_elapsed_time),
    .in_meas_x              (in_meas_x),
    .in_meas_y              (in_meas_y),
    .in_meas_z              (in_meas_z),
    .in_meas_variance       (in_meas_variance),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_est_x              (out_est_x),
    .out_est_y              (out_est_y),
    .out_est_z              (out_est_z),
    .out_est_variance       (out_est_variance),
    .out_is_initialized     (out_is_initialized),
    .out_nis                (out_nis),
    .out_nis_valid          (out_nis_valid),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_process_noise_rate (cfg_process_noise_rate),
    .fail_count             (fail_count),
    .pending                (pending),
    .checked                (checked)
  );

  function automatic int pick_gap();
    int n;
    if (calm) return 0;
    n = $urandom_range(0, 99);
    if (n < 60) return 0;
    if (n < 88) return $urandom_range(1, 3);
    if (n < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  function automatic logic [DW-1:0] pick_coord(logic [DW-1:0] around);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
      2, 3:    return around + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return around + $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_variance();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return U_MAX;
      2, 3:       return $urandom();
      4, 5, 6:    return $urandom_range(1, 32'h0004_0000);
      default:    return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_dt();
    case ($urandom_range(0, 9))
      0:       return {1'b1, 31'($urandom())};
      1:       return '0;
      2:       return POS_MAX;
      3:       return $urandom();
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_rate();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return U_MAX;
      2:       return $urandom();
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int n;
    n = $urandom_range(0, 99);
    if (n < 30) return KIND_PRED;
    if (n < 62) return KIND_UPD;
    if (n < 92) return KIND_QRY;
    return KIND_RST;
  endfunction

  // result side: random stall bursts, none while calm
  always @(negedge clk) begin
    if (!calm && hold_left == 0 && $urandom_range(0, 3) == 0) hold_left = pick_gap() + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(logic [1:0] kind, logic [DW-1:0] dt, logic [DW-1:0] mx,
                           logic [DW-1:0] my, logic [DW-1:0] mz, logic [DW-1:0] mv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_elapsed_time  <= dt;
    in_meas_x        <= mx;
    in_meas_y        <= my;
    in_meas_z        <= mz;
    in_meas_variance <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    kind_count[kind]++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_rate(logic [DW-1:0] rate);
    cfg_valid              <= 1'b1;
    cfg_process_noise_rate <= rate;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    rate_writes++;
  endtask

  initial begin
    int seg;
    int k;
    logic [DW-1:0] rate;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // noise rate still at its reset value
    send_item(KIND_PRED, ONE, ONE, ONE, ONE, ONE);
    send_item(KIND_QRY, '0, ONE, -ONE, 32'd5, ONE);
    send_item(KIND_UPD, '0, POS_MAX, POS_MIN, '0, '0);
    send_item(KIND_PRED, POS_MAX, '0, '0, '0, '0);
    send_item(KIND_QRY, '0, POS_MIN, POS_MAX, POS_MAX, '0);
    send_item(KIND_UPD, '0, POS_MIN, POS_MAX, U_MAX, U_MAX);
    send_item(KIND_UPD, '0, POS_MAX, POS_MIN, 32'd1, 32'd1);
    send_item(KIND_RST, U_MAX, U_MAX, U_MAX, U_MAX, U_MAX);
    send_item(KIND_UPD, '0, ONE, ONE, ONE, 32'd1);
    // c = r = 1: corrections of +-1/2 round away from zero
    send_item(KIND_UPD, '0, ONE + 32'd1, ONE - 32'd1, ONE, 32'd1);
    send_item(KIND_QRY, '0, ONE, ONE, ONE, '0);
    send_item(KIND_RST, '0, '0, '0, '0, '0);
    send_item(KIND_QRY, '0, ONE, ONE, ONE, ONE);

    settle();
    write_rate(U_MAX);
    send_item(KIND_PRED, ONE, '0, '0, '0, '0);
    send_item(KIND_UPD, '0, -ONE, ONE << 1, '0, ONE);
    send_item(KIND_PRED, 32'd1, '0, '0, '0, '0);
    send_item(KIND_PRED, POS_MIN, '0, '0, '0, '0);
    send_item(KIND_PRED, '0, '0, '0, '0, '0);
    send_item(KIND_PRED, POS_MAX, '0, '0, '0, '0);
    send_item(KIND_UPD, '0, POS_MAX, POS_MIN, POS_MAX, U_MAX);
    send_item(KIND_QRY, '0, POS_MIN, POS_MAX, POS_MIN, U_MAX);
    send_item(KIND_UPD, '0, ONE, -ONE, '0, '0);
    send_item(KIND_QRY, '0, '0, '0, '0, ONE);

    settle();
    write_rate(32'd1);
    send_item(KIND_PRED, ONE, '0, '0, '0, '0);
    send_item(KIND_PRED, 32'd1, '0, '0, '0, '0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0:       rate = U_MAX;
        1:       rate = '0;
        2:       rate = 32'd1;
        default: rate = pick_rate();
      endcase
      write_rate(rate);
      calm = ($urandom_range(0, 3) == 0);
      if (seg[0]) begin
        base_x = $urandom();
        base_y = $urandom();
        base_z = $urandom();
      end else begin
        base_x = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        base_y = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        base_z = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      end
      for (k = 0; k < SEGMENT_ITEMS; k++)
        send_item(pick_kind(), pick_dt(), pick_coord(base_x), pick_coord(base_y),
                  pick_coord(base_z), pick_variance());
    end

    calm = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d items sent: %0d predict, %0d update, %0d query, %0d filter reset",
             kind_count[KIND_PRED] + kind_count[KIND_UPD] + kind_count[KIND_QRY] +
             kind_count[KIND_RST], kind_count[KIND_PRED], kind_count[KIND_UPD],
             kind_count[KIND_QRY], kind_count[KIND_RST]);
    $display("%0d noise rate settings used, %0d result beats compared", rate_writes, checked);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== position_kalman_filter_3d.f =====
+incdir+rtl/core
rtl/core/pkf_pkg.sv
rtl/core/pkf_div.sv
rtl/core/pkf_seq.sv
rtl/core/pkf_dp.sv
rtl/core/position_kalman_filter_3d.sv
tb/position_estimate_checker.sv
tb/tb.sv
